// ----- rtl/core/render_target_pool_manager_defines.svh -----
// ----------------------------------------------------------------------------
// render target pool manager assertion macros
// shared concurrent assertion forms for the pool manager rtl
// ----------------------------------------------------------------------------
`ifndef RENDER_TARGET_POOL_MANAGER_DEFINES_SVH
`define RENDER_TARGET_POOL_MANAGER_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define RTPM_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rtpm invariant violated");

// consequent must hold in the cycle after the antecedent
`define RTPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtpm sequence violated");

`endif

// ----- rtl/core/rtpm_pkg.sv -----
// ----------------------------------------------------------------------------
// rtpm_pkg
// types, codes and defaults of the render target pool manager
// ----------------------------------------------------------------------------
package rtpm_pkg;

    localparam int POOL_ENTRIES_DEF = 32;

    localparam int DIM_W   = 14;
    localparam int WORD_W  = 32;
    localparam int RET_W   = 16;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 3;

    localparam logic [RET_W-1:0] RETENTION_RESET = 16'd120;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ACQUIRE     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BEGIN_FRAME = 2'd1;
    localparam logic [REQ_W-1:0] REQ_END_FRAME   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SHUTDOWN    = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_GROUP_REUSE  = 3'd0;
    localparam logic [STAT_W-1:0] ST_COMPAT_REUSE = 3'd1;
    localparam logic [STAT_W-1:0] ST_CREATED      = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_SIZE     = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL         = 3'd4;
    localparam logic [STAT_W-1:0] ST_FRAME_BEGUN  = 3'd5;
    localparam logic [STAT_W-1:0] ST_RETIRED      = 3'd6;
    localparam logic [STAT_W-1:0] ST_DONE         = 3'd7;

    // configuration register indexes
    localparam logic CFG_ALIASING  = 1'b0;
    localparam logic CFG_RETENTION = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [WORD_W-1:0] format;
        logic [WORD_W-1:0] group;
        logic [WORD_W-1:0] touched;
        logic [WORD_W-1:0] handle;
    } slot_meta_t;

endpackage

// ----- rtl/core/rtpm_ram.sv -----
// ----------------------------------------------------------------------------
// rtpm_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rtpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/render_target_pool_manager.sv -----
// ----------------------------------------------------------------------------
// render_target_pool_manager
// pooled render target table with acquire, frame and retirement requests
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one request: tuser = req_type, tdata = width, height,
//   format, group. m_ channel carries results: tuser = status, tlast = final
//   result of the request, tdata = handle, group reuse total.
//   cfg channel writes aliasing_enabled (index 0) and retention_frames (index 1);
//   it is always ready; use only while the block is idle, which it does not enforce
// sequence of each request:
//   acquire: up to two scan passes (group, then compatible) through the shared
//   entry comparator, then an emit step
//   begin frame: one busy bit cleared per cycle, then an emit step
//   end frame / shutdown: per entry a ram read, then compare and compact; each
//   retired handle is emitted as its own result, then a done result follows
//   s_tready is high only in idle, so the next request can be taken in the
//   cycle after the final result is loaded, even while that result waits
// reset: table empty, frame 0, next handle 1, reuse count 0, retention 120.
// a stalled receiver holds the sequencer in its emit step; nothing is lost.
// ----------------------------------------------------------------------------
`include "render_target_pool_manager_defines.svh"

module render_target_pool_manager
    import rtpm_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // target_width, target_height, pixel_format, alias_group
    input  logic [1:0]  s_tuser,   // req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // handle, group_reuse_total
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast,   // is_last
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(POOL_ENTRIES + 1);
    localparam int META_W = $bits(slot_meta_t);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_CLR    = 3'd2;
    localparam logic [2:0] S_RISSUE = 3'd3;
    localparam logic [2:0] S_REVAL  = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic              pass_reg, pass_next;   // 0 group pass, 1 compatible pass
    logic              chk_reg, chk_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0]  wr_reg, wr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] frame_reg, frame_next;
    logic [WORD_W-1:0] next_handle_reg, next_handle_next;
    logic [WORD_W-1:0] reuse_reg, reuse_next;
    logic              alias_en_reg, alias_en_next;
    logic [RET_W-1:0]  retention_reg, retention_next;

    logic [DIM_W-1:0]  req_w_reg, req_w_next;
    logic [DIM_W-1:0]  req_h_reg, req_h_next;
    logic [WORD_W-1:0] req_fmt_reg, req_fmt_next;
    logic [WORD_W-1:0] req_grp_reg, req_grp_next;
    logic              req_all_reg, req_all_next;

    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [WORD_W-1:0] res_handle_reg, res_handle_next;
    logic              res_last_reg, res_last_next;

    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [WORD_W-1:0] m_handle_reg, m_handle_next;
    logic              m_last_reg, m_last_next;
    logic [WORD_W-1:0] m_total_reg, m_total_next;

    slot_meta_t        meta_rd, meta_wdata;
    logic [META_W-1:0] meta_rd_bits;
    logic              meta_we, busy_we, busy_wdata, busy_rd;
    logic [IDX_W-1:0]  meta_waddr, busy_waddr, rd_addr;

    logic              slot_match, hit, pass_end, keep, create_fire;
    logic [WORD_W-1:0] age, handle_inc;
    logic [DIM_W-1:0]  in_w, in_h;
    logic [WORD_W-1:0] in_fmt, in_grp;

    assign in_w   = s_tdata[13:0];
    assign in_h   = s_tdata[27:14];
    assign in_fmt = s_tdata[59:28];
    assign in_grp = s_tdata[91:60];

    assign meta_rd = slot_meta_t'(meta_rd_bits);

    rtpm_ram #(.WIDTH(META_W), .DEPTH(POOL_ENTRIES)) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (rd_addr),
        .rdata (meta_rd_bits)
    );

    rtpm_ram #(.WIDTH(1), .DEPTH(POOL_ENTRIES)) u_busy_ram (
        .aclk  (aclk),
        .we    (busy_we),
        .waddr (busy_waddr),
        .wdata (busy_wdata),
        .raddr (rd_addr),
        .rdata (busy_rd)
    );

    // shared entry comparator
    always_comb begin
        slot_match = !busy_rd && meta_rd.width == req_w_reg && meta_rd.height == req_h_reg
                     && meta_rd.format == req_fmt_reg
                     && (meta_rd.group == req_grp_reg
                         || (pass_reg && meta_rd.group == '0));
    end

    assign hit        = chk_reg && slot_match;
    assign pass_end   = !hit && scan_reg == count_reg;
    assign age        = frame_reg - meta_rd.touched;
    assign keep       = !req_all_reg && (busy_rd || age <= {16'd0, retention_reg});
    assign handle_inc = next_handle_reg + 32'd1;

    assign s_tready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {m_total_reg, m_handle_reg};
    assign m_tuser   = m_status_reg;
    assign m_tlast   = m_last_reg;

    always_comb begin
        state_next       = state_reg;
        pass_next        = pass_reg;
        chk_next         = chk_reg;
        chk_idx_next     = chk_idx_reg;
        scan_next        = scan_reg;
        wr_next          = wr_reg;
        count_next       = count_reg;
        frame_next       = frame_reg;
        next_handle_next = next_handle_reg;
        reuse_next       = reuse_reg;
        alias_en_next    = alias_en_reg;
        retention_next   = retention_reg;
        req_w_next       = req_w_reg;
        req_h_next       = req_h_reg;
        req_fmt_next     = req_fmt_reg;
        req_grp_next     = req_grp_reg;
        req_all_next     = req_all_reg;
        res_status_next  = res_status_reg;
        res_handle_next  = res_handle_reg;
        res_last_next    = res_last_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_status_next    = m_status_reg;
        m_handle_next    = m_handle_reg;
        m_last_next      = m_last_reg;
        m_total_next     = m_total_reg;

        meta_we     = 1'b0;
        meta_waddr  = chk_idx_reg;
        meta_wdata  = meta_rd;
        busy_we     = 1'b0;
        busy_waddr  = chk_idx_reg;
        busy_wdata  = 1'b0;
        rd_addr     = scan_reg[IDX_W-1:0];
        create_fire = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_ALIASING:  alias_en_next  = cfg_data[0];
                CFG_RETENTION: retention_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_w_next   = in_w;
                    req_h_next   = in_h;
                    req_fmt_next = in_fmt;
                    req_grp_next = in_grp;
                    req_all_next = s_tuser == REQ_SHUTDOWN;
                    scan_next    = '0;
                    wr_next      = '0;
                    chk_next     = 1'b0;
                    case (s_tuser)
                        REQ_ACQUIRE: begin
                            if (in_w == '0 || in_h == '0) begin
                                res_status_next = ST_BAD_SIZE;
                                res_handle_next = '0;
                                res_last_next   = 1'b1;
                                state_next      = S_EMIT;
                            end else begin
                                pass_next  = !(alias_en_reg && in_grp != '0);
                                state_next = S_SCAN;
                            end
                        end
                        REQ_BEGIN_FRAME: begin
                            frame_next = frame_reg + 32'd1;
                            state_next = S_CLR;
                        end
                        default: begin
                            state_next = S_RISSUE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    meta_we            = 1'b1;
                    meta_wdata.group   = req_grp_reg;
                    meta_wdata.touched = frame_reg;
                    busy_we            = 1'b1;
                    busy_wdata         = 1'b1;
                    if (!pass_reg) begin
                        reuse_next      = reuse_reg + 32'd1;
                        res_status_next = ST_GROUP_REUSE;
                    end else begin
                        res_status_next = ST_COMPAT_REUSE;
                    end
                    res_handle_next = meta_rd.handle;
                    res_last_next   = 1'b1;
                    chk_next        = 1'b0;
                    state_next      = S_EMIT;
                end else if (pass_end) begin
                    chk_next = 1'b0;
                    if (!pass_reg) begin
                        pass_next = 1'b1;
                        scan_next = '0;
                    end else begin
                        res_last_next = 1'b1;
                        state_next    = S_EMIT;
                        if (count_reg == CNT_W'(POOL_ENTRIES)) begin
                            res_status_next = ST_FULL;
                            res_handle_next = '0;
                        end else begin
                            // append at the end of the table
                            create_fire        = 1'b1;
                            meta_we            = 1'b1;
                            meta_waddr         = count_reg[IDX_W-1:0];
                            meta_wdata.width   = req_w_reg;
                            meta_wdata.height  = req_h_reg;
                            meta_wdata.format  = req_fmt_reg;
                            meta_wdata.group   = req_grp_reg;
                            meta_wdata.touched = frame_reg;
                            meta_wdata.handle  = next_handle_reg;
                            busy_we            = 1'b1;
                            busy_waddr         = count_reg[IDX_W-1:0];
                            busy_wdata         = 1'b1;
                            count_next         = count_reg + CNT_W'(1);
                            next_handle_next   = (handle_inc == '0) ? 32'd1 : handle_inc;
                            res_status_next    = ST_CREATED;
                            res_handle_next    = next_handle_reg;
                        end
                    end
                end else if (scan_reg < count_reg) begin
                    // read one entry ahead of the compare
                    chk_next     = 1'b1;
                    chk_idx_next = scan_reg[IDX_W-1:0];
                    scan_next    = scan_reg + CNT_W'(1);
                end else begin
                    chk_next = 1'b0;
                end
            end
            S_CLR: begin
                if (scan_reg == count_reg) begin
                    res_status_next = ST_FRAME_BEGUN;
                    res_handle_next = '0;
                    res_last_next   = 1'b1;
                    state_next      = S_EMIT;
                end else begin
                    busy_we    = 1'b1;
                    busy_waddr = scan_reg[IDX_W-1:0];
                    busy_wdata = 1'b0;
                    scan_next  = scan_reg + CNT_W'(1);
                end
            end
            S_RISSUE: begin
                if (scan_reg == count_reg) begin
                    count_next      = wr_reg;
                    res_status_next = ST_DONE;
                    res_handle_next = '0;
                    res_last_next   = 1'b1;
                    state_next      = S_EMIT;
                end else begin
                    state_next = S_REVAL;
                end
            end
            S_REVAL: begin
                scan_next = scan_reg + CNT_W'(1);
                if (keep) begin
                    // compact: copy kept entry down to the write pointer
                    meta_we    = 1'b1;
                    meta_waddr = wr_reg[IDX_W-1:0];
                    busy_we    = 1'b1;
                    busy_waddr = wr_reg[IDX_W-1:0];
                    busy_wdata = busy_rd;
                    wr_next    = wr_reg + CNT_W'(1);
                    state_next = S_RISSUE;
                end else begin
                    res_status_next = ST_RETIRED;
                    res_handle_next = meta_rd.handle;
                    res_last_next   = 1'b0;
                    state_next      = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_handle_next = res_handle_reg;
                    m_last_next   = res_last_reg;
                    m_total_next  = reuse_reg;
                    state_next    = res_last_reg ? S_IDLE : S_RISSUE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            chk_reg         <= 1'b0;
            count_reg       <= '0;
            frame_reg       <= '0;
            next_handle_reg <= 32'd1;
            reuse_reg       <= '0;
            alias_en_reg    <= 1'b0;
            retention_reg   <= RETENTION_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            chk_reg         <= chk_next;
            count_reg       <= count_next;
            frame_reg       <= frame_next;
            next_handle_reg <= next_handle_next;
            reuse_reg       <= reuse_next;
            alias_en_reg    <= alias_en_next;
            retention_reg   <= retention_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pass_reg       <= pass_next;
        chk_idx_reg    <= chk_idx_next;
        scan_reg       <= scan_next;
        wr_reg         <= wr_next;
        req_w_reg      <= req_w_next;
        req_h_reg      <= req_h_next;
        req_fmt_reg    <= req_fmt_next;
        req_grp_reg    <= req_grp_next;
        req_all_reg    <= req_all_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_last_reg   <= res_last_next;
        m_status_reg   <= m_status_next;
        m_handle_reg   <= m_handle_next;
        m_last_reg     <= m_last_next;
        m_total_reg    <= m_total_next;
    end

    `RTPM_ASSERT_ALWAYS(a_count_range, aclk, aresetn, count_reg <= CNT_W'(POOL_ENTRIES))
    `RTPM_ASSERT_ALWAYS(a_handle_nonzero, aclk, aresetn, next_handle_reg != '0)
    `RTPM_ASSERT_ALWAYS(a_compact_order, aclk, aresetn, !(state_reg == S_REVAL) || wr_reg <= scan_reg)
    `RTPM_ASSERT_NEXT(a_create_grows, aclk, aresetn, create_fire, count_reg == $past(count_reg) + CNT_W'(1))

endmodule
